### sv/bmc_pkg.sv
package bmc_pkg;

    // field widths
    localparam int TS_W    = 8;
    localparam int LIMIT_W = 8;
    localparam int GROUP_W = 6;
    localparam int SHIFT_W = 32;
    localparam int CODE_W  = 2;
    localparam int INDEX_W = 2;
    localparam int DATA_W  = 8;
    localparam int EDGE_W  = 10;

    // edge budget per packet
    localparam int MAX_EDGES = 858;
    localparam logic [EDGE_W-1:0] EDGE_LIMIT = EDGE_W'(MAX_EDGES - 2);

    // register indexes
    localparam logic [INDEX_W-1:0] REG_SHORT_LIMIT  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [INDEX_W-1:0] REG_GROUP_BITS   = 2'd2;

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_SHORT_LIMIT  = 8'd6;
    localparam logic [LIMIT_W-1:0] RST_MAX_INTERVAL = 8'd12;
    localparam logic [GROUP_W-1:0] RST_GROUP_BITS   = 6'd5;

    // input actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

    // result kinds
    localparam logic KIND_GROUP = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // error codes
    localparam logic [CODE_W-1:0] ERR_ZERO       = 2'd0;
    localparam logic [CODE_W-1:0] ERR_TOO_LONG   = 2'd1;
    localparam logic [CODE_W-1:0] ERR_SECOND_HALF = 2'd2;
    localparam logic [CODE_W-1:0] ERR_BUDGET     = 2'd3;

    typedef struct packed {
        logic [LIMIT_W-1:0] short_limit;
        logic [LIMIT_W-1:0] max_interval;
        logic [GROUP_W-1:0] group_bits;
    } cfg_t;

endpackage

### sv/bmc_if.sv
// edge timestamp channel
interface bmc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [bmc_pkg::TS_W-1:0]  timestamp;

    modport source (output valid, output action, output timestamp, input ready);
    modport sink   (input valid, input action, input timestamp, output ready);
endinterface

// decoded result channel
interface bmc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bmc_pkg::SHIFT_W-1:0]  group_value;
    logic [bmc_pkg::CODE_W-1:0]   error_code;

    modport source (output valid, output kind, output group_value, output error_code,
                    input ready);
    modport sink   (input valid, input kind, input group_value, input error_code,
                    output ready);
endinterface

// configuration write channel
interface bmc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bmc_pkg::INDEX_W-1:0]  index;
    logic [bmc_pkg::DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/bmc_cfg_regs.sv
module bmc_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    bmc_cfg_if.sink       cfg,
    output bmc_pkg::cfg_t settings
);
    import bmc_pkg::*;

    logic [LIMIT_W-1:0] short_limit_reg;
    logic [LIMIT_W-1:0] max_interval_reg;
    logic [GROUP_W-1:0] group_bits_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_limit_reg  <= RST_SHORT_LIMIT;
            max_interval_reg <= RST_MAX_INTERVAL;
            group_bits_reg   <= RST_GROUP_BITS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SHORT_LIMIT:  short_limit_reg  <= cfg.data;
                REG_MAX_INTERVAL: max_interval_reg <= cfg.data;
                REG_GROUP_BITS:   group_bits_reg   <= cfg.data[GROUP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign settings.short_limit  = short_limit_reg;
    assign settings.max_interval = max_interval_reg;
    assign settings.group_bits   = group_bits_reg;

endmodule

### sv/bmc_edge_time_decoder.sv
// Biphase mark decoder on 8-bit wrapping edge capture times.
// edges: valid/ready channel; action start loads the reference time and
//   clears the decoder, action edge supplies the next line edge time.
// results: valid/ready channel; kind group carries group_value with the
//   first received bit in bit 0, kind error carries error_code.
// cfg: valid/ready write channel (always ready), index 0 short_limit,
//   1 max_interval, 2 group_bits; write only while no transaction is open.
// Each edge transaction is decoded in the cycle it is accepted; any result is
//   registered and appears on results in the next cycle. One transaction can
//   be accepted every cycle while the single result register is free or draining.
// When results stalls with a result held, edges.ready follows results.ready
//   so the held result is never overwritten.
// After reset the decoder is halted and ignores edges until a start;
//   registers return to short_limit 6, max_interval 12, group_bits 5.
// After an error the decoder halts again until the next start.
module bmc_edge_time_decoder
(
    input  logic     clk,
    input  logic     rst_n,
    bmc_in_if.sink   edges,
    bmc_out_if.source results,
    bmc_cfg_if.sink  cfg
);
    import bmc_pkg::*;

    cfg_t settings;

    // decoder state
    logic [TS_W-1:0]    prev_time_reg,    prev_time_next;
    logic               half_pending_reg, half_pending_next;
    logic [SHIFT_W-1:0] bit_shift_reg,    bit_shift_next;
    logic [GROUP_W-1:0] bits_held_reg,    bits_held_next;
    logic [EDGE_W-1:0]  edges_seen_reg,   edges_seen_next;
    logic               halted_reg,       halted_next;

    // result register
    logic               out_valid_reg;
    logic               out_kind_reg,     out_kind_next;
    logic [SHIFT_W-1:0] out_value_reg,    out_value_next;
    logic [CODE_W-1:0]  out_code_reg,     out_code_next;
    logic               emit;

    logic               accept;
    logic [TS_W-1:0]    gap;
    logic               new_bit;
    logic               have_bit;
    logic [GROUP_W-1:0] group_size;
    logic [GROUP_W-1:0] held_inc;
    logic [SHIFT_W-1:0] shift_inc;
    logic [GROUP_W-1:0] lead_shift;
    logic [GROUP_W-1:0] tail_shift;
    logic [SHIFT_W-1:0] aligned;

    bmc_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    // take a transaction whenever the result slot is free or draining
    assign edges.ready = !out_valid_reg || results.ready;
    assign accept      = edges.valid && edges.ready;

    assign gap = edges.timestamp - prev_time_reg;

    // group size clamped to 1..32
    always_comb
    begin
        priority if (settings.group_bits == '0)
            group_size = GROUP_W'(1);
        else if (settings.group_bits > GROUP_W'(SHIFT_W))
            group_size = GROUP_W'(SHIFT_W);
        else
            group_size = settings.group_bits;
    end

    // decode one transaction
    always_comb
    begin
        prev_time_next    = prev_time_reg;
        half_pending_next = half_pending_reg;
        bit_shift_next    = bit_shift_reg;
        bits_held_next    = bits_held_reg;
        edges_seen_next   = edges_seen_reg;
        halted_next       = halted_reg;
        emit              = 1'b0;
        out_kind_next     = KIND_GROUP;
        out_value_next    = '0;
        out_code_next     = ERR_ZERO;
        have_bit          = 1'b0;
        new_bit           = 1'b0;
        held_inc          = bits_held_reg + GROUP_W'(1);
        shift_inc         = bit_shift_reg;
        lead_shift        = '0;
        tail_shift        = '0;
        aligned           = '0;

        if (accept)
        begin
            // an edge while halted falls through with no effect
            if (edges.action == ACT_START)
            begin
                prev_time_next    = edges.timestamp;
                half_pending_next = 1'b0;
                bit_shift_next    = '0;
                bits_held_next    = '0;
                edges_seen_next   = '0;
                halted_next       = 1'b0;
            end
            else if (!halted_reg)
            begin
                prev_time_next = edges.timestamp;
                if (!half_pending_reg)
                begin
                    // first half or full long period
                    priority if (edges_seen_reg >= EDGE_LIMIT)
                    begin
                        emit          = 1'b1;
                        out_code_next = ERR_BUDGET;
                    end
                    else if (gap == '0)
                    begin
                        emit          = 1'b1;
                        out_code_next = ERR_ZERO;
                    end
                    else if (gap > settings.max_interval)
                    begin
                        emit          = 1'b1;
                        out_code_next = ERR_TOO_LONG;
                    end
                    else
                    begin
                        edges_seen_next = edges_seen_reg + EDGE_W'(1);
                        if (gap <= settings.short_limit)
                            half_pending_next = 1'b1;
                        else
                            have_bit = 1'b1;
                    end
                end
                else
                begin
                    // second half of a one bit
                    priority if (gap == '0)
                    begin
                        emit          = 1'b1;
                        out_code_next = ERR_ZERO;
                    end
                    else if (gap > settings.short_limit)
                    begin
                        emit          = 1'b1;
                        out_code_next = ERR_SECOND_HALF;
                    end
                    else
                    begin
                        edges_seen_next   = edges_seen_reg + EDGE_W'(1);
                        half_pending_next = 1'b0;
                        have_bit          = 1'b1;
                        new_bit           = 1'b1;
                    end
                end

                if (emit)
                begin
                    halted_next   = 1'b1;
                    out_kind_next = KIND_ERROR;
                end

                // shift in the new bit, emit a group when enough are held
                if (have_bit)
                begin
                    shift_inc      = {new_bit, bit_shift_reg[SHIFT_W-1:1]};
                    bit_shift_next = shift_inc;
                    bits_held_next = held_inc;
                    if (held_inc >= group_size)
                    begin
                        lead_shift     = held_inc - group_size;
                        tail_shift     = GROUP_W'(SHIFT_W) - group_size;
                        aligned        = shift_inc << lead_shift;
                        out_value_next = aligned >> tail_shift;
                        bits_held_next = lead_shift;
                        emit           = 1'b1;
                    end
                end
            end
        end
    end

    // decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg    <= '0;
            half_pending_reg <= 1'b0;
            bit_shift_reg    <= '0;
            bits_held_reg    <= '0;
            edges_seen_reg   <= '0;
            halted_reg       <= 1'b1;
        end
        else
        begin
            prev_time_reg    <= prev_time_next;
            half_pending_reg <= half_pending_next;
            bit_shift_reg    <= bit_shift_next;
            bits_held_reg    <= bits_held_next;
            edges_seen_reg   <= edges_seen_next;
            halted_reg       <= halted_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg  <= out_kind_next;
            out_value_reg <= out_value_next;
            out_code_reg  <= out_code_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = out_kind_reg;
    assign results.group_value = out_value_reg;
    assign results.error_code  = out_code_reg;

endmodule
